[rtl/bdlp_pkg.sv]
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debouncer with long-press
// detection.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Widths of the fixed stream fields.
  localparam int unsigned FIELD_BITS = 4;
  localparam int unsigned QUERY_BITS = 16;
  localparam int unsigned TICKS_BITS = 16;
  localparam int unsigned IN_DATA_BITS = 24;
  localparam int unsigned OUT_DATA_BITS = 16;

  localparam logic [TICKS_BITS-1:0] TICKS_RESET = 16'd100;

  // A 16-bit value divided by ten is (value * 0xCCCD) >> 19, exact over the
  // whole input range.
  localparam logic [QUERY_BITS-1:0] RECIP_TEN = 16'hCCCD;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned QUOT_BITS = 2 * QUERY_BITS - RECIP_SHIFT;

  // Debounced state flags of one button.
  typedef struct packed {
    logic held;
    logic short_press;
    logic long_press;
  } lane_flags_t;

endpackage

[rtl/button_debounce_long_press_unit.sv]
// ----------------------------------------------------------------------------
// button_debounce_long_press_unit
// Four-button two-sample debouncer with short and long press detection.
// ----------------------------------------------------------------------------
// Each transaction on the slave stream is one scan tick. One button lane per
// button updates its sample, hold counter and flags in the cycle the tick is
// accepted; the query time is captured in a middle stage while the updated
// state stays in the lane registers; the merge stage divides the query by
// ten, compares it with the counters and loads the result into the output
// register.
// Throughput: one tick per cycle while the receiver takes results; the lane
// state update is the only loop.
// The long-press limit resets to 100 ticks; the user must write it through
// cfg_wr_en/cfg_wr_data only while the stream is idle, which is not enforced.
// Reset (rst, synchronous) clears all samples, counters and flags and empties
// both pipeline stages.
// When the receiver stalls, the output register holds its result and the
// middle stage can still take one more tick; after that s_axis_tready drops
// until the master side moves again.
// ----------------------------------------------------------------------------
module button_debounce_long_press_unit #(
  parameter int unsigned BUTTONS    = 4,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [bdlp_pkg::TICKS_BITS-1:0]       cfg_wr_data,   // long_press_ticks
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // raw_buttons [3:0], clear_pressed_mask [7:4], query_ms [23:8]
  input  logic [bdlp_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // held_mask [3:0], short_press_mask [7:4], long_press_mask [11:8],
  // held_over_query_mask [15:12]
  output logic [bdlp_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);
  import bdlp_pkg::*;

  logic [TICKS_BITS-1:0]              long_press_ticks;
  logic                               mid_valid;
  logic [QUERY_BITS-1:0]              mid_query;
  logic                               out_ready;
  logic                               mid_ready;
  logic                               step;
  logic [FIELD_BITS-1:0]              raw_buttons;
  logic [FIELD_BITS-1:0]              clear_mask;
  logic [BUTTONS-1:0][COUNT_BITS-1:0] counts;
  lane_flags_t [BUTTONS-1:0]          flags;

  assign raw_buttons = s_axis_tdata[FIELD_BITS-1:0];
  assign clear_mask  = s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign mid_ready     = !mid_valid || out_ready;
  assign s_axis_tready = mid_ready;
  assign step          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= TICKS_RESET;
    end else if (cfg_wr_en) begin
      long_press_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_ready) begin
      mid_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mid_query <= s_axis_tdata[2*FIELD_BITS+QUERY_BITS-1:2*FIELD_BITS];
    end
  end

  // Buttons past the four input bits see a pressed pin and no clear.
  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    logic raw_bit;
    logic clear_bit;
    if (i < FIELD_BITS) begin : g_in
      assign raw_bit   = raw_buttons[i];
      assign clear_bit = clear_mask[i];
    end else begin : g_pad
      assign raw_bit   = 1'b0;
      assign clear_bit = 1'b0;
    end

    bdlp_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .step     (step),
      .raw_bit  (raw_bit),
      .clear_bit(clear_bit),
      .limit    (long_press_ticks),
      .count    (counts[i]),
      .flags    (flags[i])
    );
  end

  bdlp_merge #(
    .BUTTONS   (BUTTONS),
    .COUNT_BITS(COUNT_BITS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (mid_valid && out_ready),
    .out_ready(m_axis_tready),
    .query_ms (mid_query),
    .counts   (counts),
    .flags    (flags),
    .out_valid(m_axis_tvalid),
    .out_data (m_axis_tdata)
  );

endmodule

[rtl/bdlp_lane.sv]
// ----------------------------------------------------------------------------
// bdlp_lane
// State of one button: last sample, hold counter, short and long flags.
// ----------------------------------------------------------------------------
module bdlp_lane #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           raw_bit,
  input  logic                           clear_bit,
  input  logic [bdlp_pkg::TICKS_BITS-1:0] limit,
  output logic [COUNT_BITS-1:0]          count,
  output bdlp_pkg::lane_flags_t          flags
);
  import bdlp_pkg::*;

  localparam int unsigned CMP_BITS = (COUNT_BITS > TICKS_BITS) ? COUNT_BITS : TICKS_BITS;

  logic                  newest_sample;
  logic                  short_flag;
  logic                  long_flag;
  logic [COUNT_BITS-1:0] count_next;
  logic                  short_flag_next;
  logic                  long_flag_next;
  logic                  agree;
  logic                  can_rise;

  // The older sample after the shift equals the current newest sample, so
  // the two agree exactly when the incoming bit matches it.
  assign agree = (raw_bit == newest_sample);

  // A counter that saturates below the limit treats its top value as the limit.
  assign can_rise = (CMP_BITS'(count) < CMP_BITS'(limit)) && (count != {COUNT_BITS{1'b1}});

  always_comb begin
    count_next      = count;
    long_flag_next  = long_flag;
    short_flag_next = short_flag & ~clear_bit;
    if (agree) begin
      if (!raw_bit) begin
        if (can_rise) begin
          count_next = count + COUNT_BITS'(1);
        end else begin
          long_flag_next = 1'b1;
        end
      end else begin
        short_flag_next = (count != '0) && !long_flag;
        count_next      = '0;
        long_flag_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_sample <= 1'b0;
      count         <= '0;
      short_flag    <= 1'b0;
      long_flag     <= 1'b0;
    end else if (step) begin
      newest_sample <= raw_bit;
      count         <= count_next;
      short_flag    <= short_flag_next;
      long_flag     <= long_flag_next;
    end
  end

  assign flags.held        = (count != '0);
  assign flags.short_press = short_flag;
  assign flags.long_press  = long_flag;

endmodule

[rtl/bdlp_merge.sv]
// ----------------------------------------------------------------------------
// bdlp_merge
// Combines the lane states into the result masks and holds the result in
// the output register.
// ----------------------------------------------------------------------------
module bdlp_merge #(
  parameter int unsigned BUTTONS    = 4,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  logic                                      out_ready,
  input  logic [bdlp_pkg::QUERY_BITS-1:0]            query_ms,
  input  logic [BUTTONS-1:0][COUNT_BITS-1:0]         counts,
  input  bdlp_pkg::lane_flags_t [BUTTONS-1:0]        flags,
  output logic                                      out_valid,
  output logic [bdlp_pkg::OUT_DATA_BITS-1:0]         out_data
);
  import bdlp_pkg::*;

  localparam int unsigned CMP_BITS = (COUNT_BITS > QUOT_BITS) ? COUNT_BITS : QUOT_BITS;

  logic [2*QUERY_BITS-1:0] product;
  logic [QUOT_BITS-1:0]    quotient;
  logic [FIELD_BITS-1:0]   held_m;
  logic [FIELD_BITS-1:0]   short_m;
  logic [FIELD_BITS-1:0]   long_m;
  logic [FIELD_BITS-1:0]   over_m;

  assign product  = (2*QUERY_BITS)'(query_ms) * (2*QUERY_BITS)'(RECIP_TEN);
  assign quotient = product[2*QUERY_BITS-1:RECIP_SHIFT];

  // Only the first four buttons reach the result; missing buttons read zero.
  for (genvar i = 0; i < FIELD_BITS; i++) begin : g_bit
    if (i < BUTTONS) begin : g_lane
      assign held_m[i]  = flags[i].held;
      assign short_m[i] = flags[i].short_press;
      assign long_m[i]  = flags[i].long_press;
      assign over_m[i]  = CMP_BITS'(counts[i]) > CMP_BITS'(quotient);
    end else begin : g_none
      assign held_m[i]  = 1'b0;
      assign short_m[i] = 1'b0;
      assign long_m[i]  = 1'b0;
      assign over_m[i]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {over_m, long_m, short_m, held_m};
    end
  end

endmodule

[rtl/bdlp_checker.sv]
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks for the button debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module bdlp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [bdlp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
  import bdlp_pkg::*;

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A counter above the query is nonzero, so such a button is held.
  a_over_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tdata[4*FIELD_BITS-1:3*FIELD_BITS] & ~m_axis_tdata[FIELD_BITS-1:0]) == '0))
    else $error("held over query without held");

  // With the output register empty the pipeline cannot be blocked.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind button_debounce_long_press_unit bdlp_checker u_bdlp_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
